### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/fvg_pkg.sv
// ----------------------------------------------------------------------------
// fvg_pkg
// Types and constants of the FAT volume geometry block.
// ----------------------------------------------------------------------------
package fvg_pkg;

    localparam int DivBits = 32;
    localparam int DvsBits = 16;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_SECTOR_SIZE = 4'd1;
    localparam logic [3:0] ST_ZERO_CLUS   = 4'd2;
    localparam logic [3:0] ST_ZERO_RSV    = 4'd3;
    localparam logic [3:0] ST_NO_SECTORS  = 4'd4;
    localparam logic [3:0] ST_NO_FATSZ    = 4'd5;
    localparam logic [3:0] ST_NO_DATA     = 4'd6;
    localparam logic [3:0] ST_NO_CLUS     = 4'd7;
    localparam logic [3:0] ST_ROOT32      = 4'd8;

    localparam logic [1:0] TYPE_FAT12 = 2'd0;
    localparam logic [1:0] TYPE_FAT16 = 2'd1;
    localparam logic [1:0] TYPE_FAT32 = 2'd2;

    localparam logic [31:0] MAX_SECTOR_SIZE = 32'd4096;
    localparam logic [16:0] HDR_LONG_TOTAL  = 17'd54;
    localparam logic [16:0] HDR_FAT32       = 17'd90;
    localparam logic [31:0] CLUS_FAT16_MIN  = 32'd4085;
    localparam logic [31:0] CLUS_FAT32_MIN  = 32'd65525;
    localparam logic [31:0] RECIP_3         = 32'hAAAA_AAAB;

    typedef struct packed {
        logic [15:0] bytes_per_sector;
        logic [7:0]  cluster_sectors;
        logic [15:0] reserved_sectors;
        logic [7:0]  fat_count;
        logic [15:0] root_entries;
        logic [15:0] total_sectors_short;
        logic [31:0] total_sectors_long;
        logic [15:0] fat_sectors_short;
        logic [31:0] fat_sectors_long;
        logic [31:0] root_start_cluster;
        logic [15:0] info_sector;
        logic [16:0] header_length;
    } item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [1:0]  fat_type;
        logic [31:0] total_sector_count;
        logic [31:0] fat_table_sectors;
        logic [31:0] root_area_offset;
        logic [31:0] root_area_sectors;
        logic [31:0] data_area_offset;
        logic [31:0] data_area_sectors;
        logic [31:0] data_clusters;
        logic [31:0] max_mappable_clusters;
        logic [31:0] root_cluster_out;
        logic [15:0] info_sector_out;
    } result_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [1:0]  fat_type;
        logic [31:0] total;
        logic [31:0] fatsz;
        logic [15:0] bps;
        logic [7:0]  spc;
        logic [15:0] rsv;
        logic [7:0]  nfat;
        logic [31:0] root_num;
        logic [31:0] nprod;
        logic [31:0] maxraw;
        logic [31:0] root_off;
        logic [31:0] root_sz;
        logic [31:0] data_off;
        logic [31:0] data_sz;
        logic [31:0] clusters;
        logic [30:0] max3;
        logic [31:0] rclus;
        logic [15:0] fsinfo;
    } ctx_t;

endpackage

### rtl/core/fat_volume_geometry.sv
// ----------------------------------------------------------------------------
// fat_volume_geometry
// FAT parameter block in, volume layout and FAT type out.
// ----------------------------------------------------------------------------
// channel   ports                 direction  beat
// item      start, busy, item     in         start & !busy
// result    done, result          out        done, one cycle
//
// One beat accepted per cycle; busy stays low.
// Each item passes s0 to s3, the two 32-stage dividers (root size, clusters) with s4 between, s5 and out.
// Reset clears the valid bits only; no clearing pass.
// Results cannot be stalled; each shows for one cycle with done.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fat_volume_geometry (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  fvg_pkg::item_t   item,
    output logic             done,
    output fvg_pkg::result_t result
);

    logic             s0_valid_reg;
    fvg_pkg::item_t   s0_item_reg;
    logic             s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic             s5_valid_reg, out_valid_reg;
    fvg_pkg::ctx_t    s1_reg, s2_reg, s3_reg, s4_reg, s5_reg;
    fvg_pkg::ctx_t    s1_next, s2_next, s3_next, s4_next, s5_next;
    fvg_pkg::result_t out_reg, out_next;

    logic             d1_valid, d2_valid;
    logic [31:0]      d1_quo, d2_quo;
    fvg_pkg::ctx_t    d1_ctx, d2_ctx;

    logic [31:0]      total_sel, fatsz_sel, data_off_sum;
    logic             is32form;
    logic [63:0]      recip_prod;

    assign busy = 1'b0;

    always_comb
    begin
        s1_next = '0;
        if (s0_item_reg.total_sectors_short != 16'd0)
            total_sel = {16'd0, s0_item_reg.total_sectors_short};
        else if (s0_item_reg.header_length >= fvg_pkg::HDR_LONG_TOTAL)
            total_sel = s0_item_reg.total_sectors_long;
        else
            total_sel = '0;
        is32form = (s0_item_reg.header_length >= fvg_pkg::HDR_FAT32)
                && (s0_item_reg.root_entries == 16'd0)
                && (s0_item_reg.total_sectors_short == 16'd0)
                && (s0_item_reg.fat_sectors_short == 16'd0);
        if (s0_item_reg.fat_sectors_short != 16'd0)
            fatsz_sel = {16'd0, s0_item_reg.fat_sectors_short};
        else if (is32form)
            fatsz_sel = s0_item_reg.fat_sectors_long;
        else
            fatsz_sel = '0;

        if (s0_item_reg.bytes_per_sector == 16'd0
            || {16'd0, s0_item_reg.bytes_per_sector} > fvg_pkg::MAX_SECTOR_SIZE)
            s1_next.status = fvg_pkg::ST_SECTOR_SIZE;
        else if (s0_item_reg.cluster_sectors == 8'd0)
            s1_next.status = fvg_pkg::ST_ZERO_CLUS;
        else if (s0_item_reg.reserved_sectors == 16'd0)
            s1_next.status = fvg_pkg::ST_ZERO_RSV;
        else if (total_sel == 32'd0)
            s1_next.status = fvg_pkg::ST_NO_SECTORS;
        else if (fatsz_sel == 32'd0)
            s1_next.status = fvg_pkg::ST_NO_FATSZ;
        else
            s1_next.status = fvg_pkg::ST_OK;

        s1_next.total    = total_sel;
        s1_next.fatsz    = fatsz_sel;
        s1_next.bps      = s0_item_reg.bytes_per_sector;
        s1_next.spc      = s0_item_reg.cluster_sectors;
        s1_next.rsv      = s0_item_reg.reserved_sectors;
        s1_next.nfat     = s0_item_reg.fat_count;
        s1_next.root_num = {11'd0, s0_item_reg.root_entries, 5'd0}
                         + {16'd0, s0_item_reg.bytes_per_sector} - 32'd1;
        s1_next.rclus    = s0_item_reg.root_start_cluster;
        s1_next.fsinfo   = s0_item_reg.info_sector;
    end

    always_comb
    begin
        s2_next        = s1_reg;
        s2_next.nprod  = {24'd0, s1_reg.nfat} * s1_reg.fatsz;
        s2_next.maxraw = s1_reg.fatsz * {16'd0, s1_reg.bps};
    end

    always_comb
    begin
        s3_next          = s2_reg;
        s3_next.root_off = {16'd0, s2_reg.rsv} + s2_reg.nprod;
    end

    fvg_div u_root_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .dividend  (s3_reg.root_num),
        .divisor   (s3_reg.bps),
        .ctx_in    (s3_reg),
        .out_valid (d1_valid),
        .quotient  (d1_quo),
        .ctx_out   (d1_ctx)
    );

    always_comb
    begin
        s4_next          = d1_ctx;
        data_off_sum     = d1_ctx.root_off + d1_quo;
        s4_next.root_sz  = d1_quo;
        s4_next.data_off = data_off_sum;
        s4_next.data_sz  = d1_ctx.total - data_off_sum;
        if (d1_ctx.status == fvg_pkg::ST_OK && d1_ctx.total <= data_off_sum)
            s4_next.status = fvg_pkg::ST_NO_DATA;
    end

    fvg_div u_clus_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s4_valid_reg),
        .dividend  (s4_reg.data_sz),
        .divisor   ({8'd0, s4_reg.spc}),
        .ctx_in    (s4_reg),
        .out_valid (d2_valid),
        .quotient  (d2_quo),
        .ctx_out   (d2_ctx)
    );

    always_comb
    begin
        s5_next          = d2_ctx;
        s5_next.clusters = d2_quo;
        recip_prod       = {32'd0, d2_ctx.maxraw} * {32'd0, fvg_pkg::RECIP_3};
        s5_next.max3     = recip_prod[63:33];
        if (d2_quo < fvg_pkg::CLUS_FAT16_MIN)
            s5_next.fat_type = fvg_pkg::TYPE_FAT12;
        else if (d2_quo < fvg_pkg::CLUS_FAT32_MIN)
            s5_next.fat_type = fvg_pkg::TYPE_FAT16;
        else
            s5_next.fat_type = fvg_pkg::TYPE_FAT32;
        if (d2_ctx.status == fvg_pkg::ST_OK)
        begin
            if (d2_quo == 32'd0)
                s5_next.status = fvg_pkg::ST_NO_CLUS;
            else if (d2_quo >= fvg_pkg::CLUS_FAT32_MIN && d2_ctx.root_sz != 32'd0)
                s5_next.status = fvg_pkg::ST_ROOT32;
        end
    end

    always_comb
    begin
        out_next        = '0;
        out_next.status = s5_reg.status;
        if (s5_reg.status == fvg_pkg::ST_OK)
        begin
            out_next.fat_type           = s5_reg.fat_type;
            out_next.total_sector_count = s5_reg.total;
            out_next.fat_table_sectors  = s5_reg.fatsz;
            out_next.root_area_sectors  = s5_reg.root_sz;
            out_next.data_area_offset   = s5_reg.data_off;
            out_next.data_area_sectors  = s5_reg.data_sz;
            out_next.data_clusters      = s5_reg.clusters;
            case (s5_reg.fat_type)
                fvg_pkg::TYPE_FAT12:
                begin
                    out_next.root_area_offset      = s5_reg.root_off;
                    out_next.max_mappable_clusters = {s5_reg.max3, 1'b0};
                end
                fvg_pkg::TYPE_FAT16:
                begin
                    out_next.root_area_offset      = s5_reg.root_off;
                    out_next.max_mappable_clusters = {1'b0, s5_reg.maxraw[31:1]};
                end
                default:
                begin
                    out_next.max_mappable_clusters = {2'b0, s5_reg.maxraw[31:2]};
                    out_next.root_cluster_out      = s5_reg.rclus;
                    out_next.info_sector_out       = s5_reg.fsinfo;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= start & ~busy;
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= d1_valid;
            s5_valid_reg  <= d2_valid;
            out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_item_reg <= item;
        s1_reg      <= s1_next;
        s2_reg      <= s2_next;
        s3_reg      <= s3_next;
        s4_reg      <= s4_next;
        s5_reg      <= s5_next;
        out_reg     <= out_next;
    end

    assign done   = out_valid_reg;
    assign result = out_reg;

    `ASSERT_IMPL(a_err_zeroed, done && result.status != fvg_pkg::ST_OK,
        result.fat_type == fvg_pkg::TYPE_FAT12 && result.total_sector_count == 32'd0)
    `ASSERT_IMPL(a_ok_has_clusters, done && result.status == fvg_pkg::ST_OK,
        result.data_clusters != 32'd0)
    `ASSERT_IMPL(a_fat32_no_root, done && result.fat_type == fvg_pkg::TYPE_FAT32,
        result.root_area_offset == 32'd0 && result.root_area_sectors == 32'd0)
    `ASSERT_NEXT(a_div_flow, d1_valid, s4_valid_reg)

endmodule

### rtl/core/fvg_div.sv
// ----------------------------------------------------------------------------
// fvg_div
// Pipelined restoring divider, one quotient bit per stage, context alongside.
// ----------------------------------------------------------------------------
module fvg_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [fvg_pkg::DivBits-1:0]      dividend,
    input  logic [fvg_pkg::DvsBits-1:0]      divisor,
    input  fvg_pkg::ctx_t                    ctx_in,
    output logic                             out_valid,
    output logic [fvg_pkg::DivBits-1:0]      quotient,
    output fvg_pkg::ctx_t                    ctx_out
);

    logic                            valid_reg [fvg_pkg::DivBits];
    logic [fvg_pkg::DvsBits-1:0]     rem_reg   [fvg_pkg::DivBits];
    logic [fvg_pkg::DivBits-1:0]     quo_reg   [fvg_pkg::DivBits];
    logic [fvg_pkg::DvsBits-1:0]     dvs_reg   [fvg_pkg::DivBits];
    fvg_pkg::ctx_t                   ctx_reg   [fvg_pkg::DivBits];

    genvar k;
    generate
        for (k = 0; k < fvg_pkg::DivBits; k++)
        begin : g_stage
            logic                        v_src;
            logic [fvg_pkg::DvsBits-1:0] r_src;
            logic [fvg_pkg::DivBits-1:0] q_src;
            logic [fvg_pkg::DvsBits-1:0] d_src;
            fvg_pkg::ctx_t               c_src;
            logic [fvg_pkg::DvsBits:0]   part;
            logic [fvg_pkg::DvsBits-1:0] rem_next;
            logic [fvg_pkg::DivBits-1:0] quo_next;

            if (k == 0)
            begin : g_first
                assign v_src = in_valid;
                assign r_src = '0;
                assign q_src = dividend;
                assign d_src = divisor;
                assign c_src = ctx_in;
            end
            else
            begin : g_rest
                assign v_src = valid_reg[k-1];
                assign r_src = rem_reg[k-1];
                assign q_src = quo_reg[k-1];
                assign d_src = dvs_reg[k-1];
                assign c_src = ctx_reg[k-1];
            end

            always_comb
            begin
                part = {r_src, q_src[fvg_pkg::DivBits-1]};
                if (part >= {1'b0, d_src})
                begin
                    rem_next = fvg_pkg::DvsBits'(part - {1'b0, d_src});
                    quo_next = {q_src[fvg_pkg::DivBits-2:0], 1'b1};
                end
                else
                begin
                    rem_next = part[fvg_pkg::DvsBits-1:0];
                    quo_next = {q_src[fvg_pkg::DivBits-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[k] <= 1'b0;
                else
                    valid_reg[k] <= v_src;
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
                dvs_reg[k] <= d_src;
                ctx_reg[k] <= c_src;
            end
        end
    endgenerate

    assign out_valid = valid_reg[fvg_pkg::DivBits-1];
    assign quotient  = quo_reg[fvg_pkg::DivBits-1];
    assign ctx_out   = ctx_reg[fvg_pkg::DivBits-1];

endmodule
